/* sv/gssm_pkg.sv */
package gssm_pkg;

	localparam int RATE_W     = 24;
	localparam int RES_FRAC   = 16;
	localparam int EXTRA_W    = 24;
	localparam int FT_W       = 16;
	localparam int THR_W      = 23;
	localparam int SENS_CFG_W = 16;
	localparam int MOVE_W     = 16;
	localparam int Q_DEPTH    = 2;
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);

	localparam int SQ_W      = 2 * RATE_W;
	localparam int ROOT_W    = RATE_W;
	localparam int REM_W     = ROOT_W + 2;
	localparam int RATIO_W   = 17;
	localparam int QUO_W     = 16;
	localparam int GAIN_W    = 2 * SENS_CFG_W;
	localparam int BLEND_W   = GAIN_W + RATIO_W;
	localparam int SENS_W    = GAIN_W;
	localparam int PT_W      = RATE_W + SENS_W;
	localparam int T_W       = RATE_W + SENS_W - 16;
	localparam int U_SHIFT   = 24 - RES_FRAC;
	localparam int PU_W      = T_W + FT_W;
	localparam int U_W       = T_W + FT_W - U_SHIFT;
	localparam int TOT_W     = U_W + 2;
	localparam int RESID_W   = RES_FRAC + 1;
	localparam int WHOLE_W   = TOT_W - RES_FRAC;
	localparam int CNT_W     = $clog2(ROOT_W);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_LOW_SENS  = 3'd0,
		REG_HIGH_SENS = 3'd1,
		REG_LOW_THR   = 3'd2,
		REG_HIGH_THR  = 3'd3,
		REG_CAL_GAIN  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_EXC,
		ST_DIV,
		ST_GAIN,
		ST_BLEND,
		ST_SENS,
		ST_TX,
		ST_TY,
		ST_UX,
		ST_UY,
		ST_SETTLE
	} state_t;

	typedef struct packed {
		logic [RATE_W-1:0]        ax;
		logic [RATE_W-1:0]        ay;
		logic                     neg_x;
		logic                     neg_y;
		logic [FT_W-1:0]          ft;
		logic signed [EXTRA_W-1:0] ex;
		logic signed [EXTRA_W-1:0] ey;
	} item_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} q_status_t;

	typedef struct packed {
		logic [SENS_CFG_W-1:0] low_sens;
		logic [SENS_CFG_W-1:0] high_sens;
		logic [THR_W-1:0]      low_thr;
		logic [THR_W-1:0]      high_thr;
		logic [SENS_CFG_W-1:0] cal_gain;
	} cfg_t;

endpackage

/* sv/gyro_shaped_sensitivity_mouse.sv */
// Gyro-shaped sensitivity to mouse counts.
//
// Input channel: one item per gyro sample (rate_x, rate_y, frame_time, extra_x,
// extra_y), taken at a rising edge with in_valid high and in_stall low.
// Output channel: one item per input item (move_x, move_y, clipped), offered
// with out_valid and taken at an edge where out_stall is low.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12, 16
// (low sensitivity, high sensitivity, low threshold, high threshold,
// calibration gain). Write only while the block holds no item in flight.
//
// The back end works on one item at a time in a single sequencer: a 24-step
// square root loop, a 16-step ramp divide when the magnitude lies inside the
// ramp, and a chain of multiply steps. It pops the next item only once the
// previous result has been committed to the output register.
// A one-stage front and a two-entry queue keep taking items while the back
// end works or while a finished result waits in the output register.
// Reset loads the register defaults and clears both residuals and all
// handshake state. When the receiver stalls, the result holds steady, the
// back end waits, and the queue then fills before in_stall is raised.
module gyro_shaped_sensitivity_mouse import gssm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [RATE_W-1:0]  rate_x,
	input  logic signed [RATE_W-1:0]  rate_y,
	input  logic [FT_W-1:0]           frame_time,
	input  logic signed [EXTRA_W-1:0] extra_x,
	input  logic signed [EXTRA_W-1:0] extra_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [MOVE_W-1:0]  move_x,
	output logic signed [MOVE_W-1:0]  move_y,
	output logic                      clipped
);

	cfg_t      cfg_q;
	q_status_t q_status;
	item_t     push_item;
	item_t     head;
	logic      push;
	logic      pop;
	logic      back_busy;
	logic      wr_en;
	reg_idx_t  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	// Register file; addresses past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_sens  <= SENS_CFG_W'(256);
			cfg_q.high_sens <= SENS_CFG_W'(256);
			cfg_q.low_thr   <= '0;
			cfg_q.high_thr  <= '0;
			cfg_q.cal_gain  <= SENS_CFG_W'(256);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LOW_SENS:  cfg_q.low_sens  <= pwdata[SENS_CFG_W-1:0];
				REG_HIGH_SENS: cfg_q.high_sens <= pwdata[SENS_CFG_W-1:0];
				REG_LOW_THR:   cfg_q.low_thr   <= pwdata[THR_W-1:0];
				REG_HIGH_THR:  cfg_q.high_thr  <= pwdata[THR_W-1:0];
				REG_CAL_GAIN:  cfg_q.cal_gain  <= pwdata[SENS_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOW_SENS:  prdata = DATA_W'(cfg_q.low_sens);
			REG_HIGH_SENS: prdata = DATA_W'(cfg_q.high_sens);
			REG_LOW_THR:   prdata = DATA_W'(cfg_q.low_thr);
			REG_HIGH_THR:  prdata = DATA_W'(cfg_q.high_thr);
			REG_CAL_GAIN:  prdata = DATA_W'(cfg_q.cal_gain);
			default:       prdata = '0;
		endcase
	end

	gssm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rate_x     (rate_x),
		.rate_y     (rate_y),
		.frame_time (frame_time),
		.extra_x    (extra_x),
		.extra_y    (extra_y),
		.q_status   (q_status),
		.push       (push),
		.push_item  (push_item)
	);

	gssm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	gssm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.busy      (back_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.move_x    (move_x),
		.move_y    (move_y),
		.clipped   (clipped)
	);

	// The queue never holds more than its depth.
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");

	// Input backpressure only appears once the queue is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_status.full)
		else $error("input stalled with room in the queue");

	// A new result only comes out of a back-end pass.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(back_busy))
		else $error("result without a back-end pass");

	// The back end never pops an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

endmodule

/* sv/gssm_front.sv */
module gssm_front import gssm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [RATE_W-1:0]  rate_x,
	input  logic signed [RATE_W-1:0]  rate_y,
	input  logic [FT_W-1:0]           frame_time,
	input  logic signed [EXTRA_W-1:0] extra_x,
	input  logic signed [EXTRA_W-1:0] extra_y,
	input  q_status_t                 q_status,
	output logic                      push,
	output item_t                     push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	// The stage holds one classified item until the queue has room.
	assign push     = valid_s1 && !q_status.full;
	assign in_stall = valid_s1 && q_status.full;
	assign take     = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.neg_x <= rate_x[RATE_W-1];
			item_s1.neg_y <= rate_y[RATE_W-1];
			item_s1.ax    <= rate_x[RATE_W-1] ? RATE_W'(-rate_x) : RATE_W'(rate_x);
			item_s1.ay    <= rate_y[RATE_W-1] ? RATE_W'(-rate_y) : RATE_W'(rate_y);
			item_s1.ft    <= frame_time;
			item_s1.ex    <= extra_x;
			item_s1.ey    <= extra_y;
		end
	end

endmodule

/* sv/gssm_queue.sv */
module gssm_queue import gssm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign status.count = cnt_q;
	assign status.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

/* sv/gssm_back.sv */
module gssm_back import gssm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  q_status_t                q_status,
	input  item_t                    head,
	output logic                     pop,
	output logic                     busy,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [MOVE_W-1:0] move_x,
	output logic signed [MOVE_W-1:0] move_y,
	output logic                     clipped
);

	state_t state_q, state_d;

	item_t               it_q;
	logic [SQ_W-1:0]     sq_q;
	logic [ROOT_W-1:0]   root_q;
	logic [REM_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [THR_W-1:0]    drem_q;
	logic [QUO_W-1:0]    quo_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic [GAIN_W-1:0]   lo_q, hi_q;
	logic [BLEND_W-1:0]  p0_q, p1_q;
	logic [SENS_W-1:0]   sens_q;
	logic [T_W-1:0]      tx_q, ty_q;
	logic [U_W-1:0]      ux_q, uy_q;
	logic signed [RESID_W-1:0] res_x_q, res_y_q;
	logic                out_valid_q;

	logic                commit;
	logic                span_pos;
	logic [THR_W-1:0]    span;
	logic [ROOT_W-1:0]   root_mag;
	logic [ROOT_W-1:0]   exc_d;
	logic                exc_in_ramp;
	logic [REM_W-1:0]    rem_shift;
	logic [REM_W-1:0]    trial;
	logic [THR_W:0]      dshift;
	logic                dge;
	logic signed [MOVE_W-1:0]  mx, my;
	logic signed [RESID_W-1:0] rx, ry;
	logic                cx, cy;

	// Sum of shaped move, scaled extra and residual, split into whole counts
	// truncated toward zero and a signed fraction. The shaped term stays below
	// 2^U_W and fits the TOT_W-bit signed sum, so it needs no cap of its own.
	function automatic logic [MOVE_W+RESID_W:0] settle(
		input logic [U_W-1:0]             u,
		input logic                       neg,
		input logic signed [EXTRA_W-1:0]  ex,
		input logic signed [RESID_W-1:0]  res
	);
		logic signed [TOT_W-1:0]   shaped;
		logic signed [TOT_W-1:0]   extra;
		logic signed [TOT_W-1:0]   total;
		logic [RES_FRAC-1:0]       frac;
		logic                      round_up;
		logic signed [WHOLE_W-1:0] whole;
		logic signed [RESID_W-1:0] resid;
		logic signed [MOVE_W-1:0]  sat;
		logic                      clip;
		shaped   = neg ? -$signed({2'b00, u}) : $signed({2'b00, u});
		extra    = TOT_W'($signed({ex, {(RES_FRAC - 8){1'b0}}}));
		total    = shaped + extra + TOT_W'(res);
		frac     = total[RES_FRAC-1:0];
		round_up = total[TOT_W-1] && (frac != '0);
		whole    = $signed(total[TOT_W-1:RES_FRAC]) + $signed({{(WHOLE_W-1){1'b0}}, round_up});
		resid    = $signed({round_up, frac});
		clip     = 1'b0;
		if (whole > $signed(WHOLE_W'(32767))) begin
			sat  = 16'sh7FFF;
			clip = 1'b1;
		end else if (whole < -$signed(WHOLE_W'(32768))) begin
			sat  = -16'sh8000;
			clip = 1'b1;
		end else begin
			sat  = MOVE_W'(whole);
		end
		return {sat, resid, clip};
	endfunction

	assign span_pos = cfg.high_thr > cfg.low_thr;
	assign span     = cfg.high_thr - cfg.low_thr;
	assign root_mag = root_q;

	// Excess over the low threshold, formed from the finished root.
	assign exc_d = (root_mag > ROOT_W'(cfg.low_thr)) ? root_mag - ROOT_W'(cfg.low_thr) : '0;
	assign exc_in_ramp = span_pos && (exc_d < ROOT_W'(span));

	assign rem_shift = {rem_q[REM_W-3:0], sq_q[SQ_W-1 -: 2]};
	assign trial     = {root_q, 2'b01};

	assign dshift = {drem_q, 1'b0};
	assign dge    = dshift >= {1'b0, span};

	assign {mx, rx, cx} = settle(ux_q, it_q.neg_x, it_q.ex, res_x_q);
	assign {my, ry, cy} = settle(uy_q, it_q.neg_y, it_q.ey, res_y_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (!q_status.empty) state_d = ST_SQX;
			ST_SQX:    state_d = ST_SQY;
			ST_SQY:    state_d = ST_ROOT;
			ST_ROOT:   if (cnt_q == '0) state_d = ST_EXC;
			ST_EXC:    state_d = exc_in_ramp ? ST_DIV : ST_GAIN;
			ST_DIV:    if (cnt_q == '0) state_d = ST_GAIN;
			ST_GAIN:   state_d = ST_BLEND;
			ST_BLEND:  state_d = ST_SENS;
			ST_SENS:   state_d = ST_TX;
			ST_TX:     state_d = ST_TY;
			ST_TY:     state_d = ST_UX;
			ST_UX:     state_d = ST_UY;
			ST_UY:     state_d = ST_SETTLE;
			ST_SETTLE: if (commit) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop    = (state_q == ST_IDLE) && !q_status.empty;
		commit = (state_q == ST_SETTLE) && (!out_valid_q || !out_stall);
		busy   = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			res_x_q     <= '0;
			res_y_q     <= '0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
				res_x_q     <= rx;
				res_y_q     <= ry;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				it_q <= head;
			end
			ST_SQX: begin
				sq_q <= SQ_W'(it_q.ax) * SQ_W'(it_q.ax);
			end
			ST_SQY: begin
				sq_q   <= sq_q + SQ_W'(it_q.ay) * SQ_W'(it_q.ay);
				root_q <= '0;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end
			ST_ROOT: begin
				sq_q <= {sq_q[SQ_W-3:0], 2'b00};
				if (rem_shift >= trial) begin
					rem_q  <= rem_shift - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_shift;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			ST_EXC: begin
				// Outside the ramp the ratio is one at or beyond its top, or a
				// step on the magnitude when the thresholds are crossed or equal.
				if (exc_in_ramp) begin
					drem_q <= THR_W'(exc_d);
					quo_q  <= '0;
					cnt_q  <= CNT_W'(QUO_W - 1);
				end else if (span_pos) begin
					ratio_q <= RATIO_W'(1 << QUO_W);
				end else begin
					ratio_q <= (exc_d != '0) ? RATIO_W'(1 << QUO_W) : '0;
				end
			end
			ST_DIV: begin
				drem_q <= dge ? THR_W'(dshift - {1'b0, span}) : dshift[THR_W-1:0];
				quo_q  <= {quo_q[QUO_W-2:0], dge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					ratio_q <= {1'b0, quo_q[QUO_W-2:0], dge};
				end
			end
			ST_GAIN: begin
				lo_q <= GAIN_W'(cfg.low_sens) * GAIN_W'(cfg.cal_gain);
				hi_q <= GAIN_W'(cfg.high_sens) * GAIN_W'(cfg.cal_gain);
			end
			ST_BLEND: begin
				p0_q <= BLEND_W'(lo_q) * BLEND_W'(RATIO_W'(1 << QUO_W) - ratio_q);
				p1_q <= BLEND_W'(hi_q) * BLEND_W'(ratio_q);
			end
			ST_SENS: begin
				sens_q <= SENS_W'((BLEND_W'(p0_q + p1_q)) >> 16);
			end
			ST_TX: tx_q <= T_W'((PT_W'(it_q.ax) * PT_W'(sens_q)) >> 16);
			ST_TY: ty_q <= T_W'((PT_W'(it_q.ay) * PT_W'(sens_q)) >> 16);
			ST_UX: ux_q <= U_W'((PU_W'(tx_q) * PU_W'(it_q.ft)) >> U_SHIFT);
			ST_UY: uy_q <= U_W'((PU_W'(ty_q) * PU_W'(it_q.ft)) >> U_SHIFT);
			ST_SETTLE: begin
				if (commit) begin
					move_x  <= mx;
					move_y  <= my;
					clipped <= cx || cy;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
